// ===== src/alrs_pkg.sv =====
// Package for the append-only log record store.
// Constants, function codes, status codes and the controller/datapath interface types.
package alrs_pkg;

  localparam int CACHE_KINDS = 10;
  localparam int LOG_SLOTS   = 256;
  localparam int IDX_W       = $clog2(CACHE_KINDS);
  localparam int USED_W      = $clog2(CACHE_KINDS + 1);
  localparam int SLOT_W      = $clog2(LOG_SLOTS + 1);

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [15:0] REC_MAGIC = 16'hC0DE;

  localparam logic [2:0] FN_SCAN    = 3'd0;
  localparam logic [2:0] FN_RECORD  = 3'd1;
  localparam logic [2:0] FN_GET     = 3'd2;
  localparam logic [2:0] FN_SAVE    = 3'd3;
  localparam logic [2:0] FN_OUTCOME = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNINIT   = 3'd1;
  localparam logic [2:0] ST_IGNORED  = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [1:0] {
    MODE_UNINIT = 2'd0,
    MODE_READY  = 2'd1,
    MODE_ERASE  = 2'd2
  } mode_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic crc_init;   // start CRC over the captured header
    logic crc_step;   // one byte of CRC
    logic use_pend;   // CRC: new save header with fixed magic; search/store: pending save
    logic search_init;
    logic search_step;
    logic cache_clear;
    logic cache_write; // write entry at search result (or new entry)
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic crc_done;
    logic crc_match;
    logic all_ff;
    logic magic_ok;
    logic search_done;
    logic hit;
    logic cache_full;
  } dp_stat_t;

endpackage

// ===== src/alrs_datapath.sv =====
// Datapath: item capture, byte-serial CRC-32, sequential cache search and cache store.
// Depends on alrs_pkg.
module alrs_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  alrs_pkg::dp_cmd_t      cmd,
  output alrs_pkg::dp_stat_t     stat,
  input  logic [15:0]            magic_word,
  input  logic [7:0]             kind,
  input  logic [7:0]             tag,
  input  logic [31:0]            value,
  input  logic [31:0]            crc_word,
  input  logic [31:0]            pad_word,
  input  logic [7:0]             pend_kind,
  input  logic [7:0]             pend_tag,
  input  logic [31:0]            pend_value,
  output logic [7:0]             r_kind,
  output logic [7:0]             r_tag,
  output logic [31:0]            r_value,
  output logic [31:0]            crc_out,
  output logic                   get_hit,
  output logic [31:0]            get_value,
  output logic [7:0]             get_tag
);

  logic [15:0] r_magic;
  logic [31:0] r_crcw, r_padw;
  logic [63:0] hdr;
  logic [31:0] crc, crc_next;
  logic [3:0]  byte_cnt;

  logic [7:0]  kind_tbl  [alrs_pkg::CACHE_KINDS];
  logic [31:0] value_tbl [alrs_pkg::CACHE_KINDS];
  logic [7:0]  tag_tbl   [alrs_pkg::CACHE_KINDS];
  logic [alrs_pkg::CACHE_KINDS-1:0] valid_tbl;
  logic [alrs_pkg::USED_W-1:0] used;
  logic [alrs_pkg::USED_W-1:0] sidx;
  logic        hit;
  logic        sdone;
  logic [7:0]  skind;
  logic [alrs_pkg::IDX_W-1:0] widx;

  always_comb begin
    crc_next = crc ^ {24'd0, hdr[7:0]};
    for (int k = 0; k < 8; k++) begin
      crc_next = crc_next[0] ? (alrs_pkg::CRC_POLY ^ (crc_next >> 1)) : (crc_next >> 1);
    end
  end

  assign skind = cmd.use_pend ? pend_kind : r_kind;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_magic <= magic_word;
      r_kind  <= kind;
      r_tag   <= tag;
      r_value <= value;
      r_crcw  <= crc_word;
      r_padw  <= pad_word;
    end
    if (cmd.crc_init) begin
      crc      <= alrs_pkg::CRC_INIT;
      byte_cnt <= '0;
      // a save always writes the fixed magic, whatever came on magic_word
      if (cmd.use_pend) begin
        hdr <= {r_value, r_tag, r_kind, alrs_pkg::REC_MAGIC[15:8],
                alrs_pkg::REC_MAGIC[7:0]};
      end else begin
        hdr <= {r_value, r_tag, r_kind, r_magic[15:8], r_magic[7:0]};
      end
    end else if (cmd.crc_step && !byte_cnt[3]) begin
      crc      <= crc_next;
      hdr      <= hdr >> 8;
      byte_cnt <= byte_cnt + 4'd1;
    end
  end

  assign crc_out = ~crc;
  assign stat.crc_done  = byte_cnt[3];
  assign stat.crc_match = (~crc) == r_crcw;
  assign stat.magic_ok  = r_magic == alrs_pkg::REC_MAGIC;
  assign stat.all_ff    = (&r_magic) && (&r_kind) && (&r_tag) && (&r_value) &&
                          (&r_crcw) && (&r_padw);

  // search: one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sidx  <= '0;
      hit   <= 1'b0;
      sdone <= 1'b0;
    end else if (cmd.search_init) begin
      sidx  <= '0;
      hit   <= 1'b0;
      sdone <= 1'b0;
    end else if (cmd.search_step && !sdone) begin
      if (sidx >= used) begin
        sdone <= 1'b1;
      end else if (kind_tbl[sidx[alrs_pkg::IDX_W-1:0]] == skind) begin
        hit   <= 1'b1;
        sdone <= 1'b1;
      end else begin
        sidx <= sidx + 1'b1;
      end
    end
  end

  assign stat.search_done = sdone;
  assign stat.hit         = hit;
  assign stat.cache_full  = used >= alrs_pkg::USED_W'(alrs_pkg::CACHE_KINDS);

  assign widx = hit ? sidx[alrs_pkg::IDX_W-1:0] : used[alrs_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      valid_tbl <= '0;
    end else if (cmd.cache_clear) begin
      used      <= '0;
      valid_tbl <= '0;
    end else if (cmd.cache_write && (hit || !stat.cache_full)) begin
      valid_tbl[widx] <= 1'b1;
      if (!hit) used <= used + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cache_write && (hit || !stat.cache_full)) begin
      kind_tbl[widx]  <= skind;
      value_tbl[widx] <= cmd.use_pend ? pend_value : r_value;
      tag_tbl[widx]   <= cmd.use_pend ? pend_tag : r_tag;
    end
  end

  assign get_hit   = hit && valid_tbl[sidx[alrs_pkg::IDX_W-1:0]];
  assign get_value = get_hit ? value_tbl[sidx[alrs_pkg::IDX_W-1:0]] : 32'd0;
  assign get_tag   = get_hit ? tag_tbl[sidx[alrs_pkg::IDX_W-1:0]] : 8'd0;

endmodule

// ===== src/alrs_ctrl.sv =====
// Controller state machine: decodes the item, sequences the datapath, holds log state
// and the registered result. Depends on alrs_pkg.
module alrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          func,
  input  logic                erase_ok,
  input  logic                program_ok,
  output logic                busy,
  output alrs_pkg::dp_cmd_t   cmd,
  input  alrs_pkg::dp_stat_t  stat,
  input  logic [7:0]          r_kind,
  input  logic [7:0]          r_tag,
  input  logic [31:0]         r_value,
  input  logic [31:0]         crc_in,
  input  logic                get_hit,
  input  logic [31:0]         get_value,
  input  logic [7:0]          get_tag,
  output logic [7:0]          pend_kind,
  output logic [7:0]          pend_tag,
  output logic [31:0]         pend_value,
  output logic                done,
  output logic [2:0]          status,
  output logic                found,
  output logic [31:0]         found_value,
  output logic [7:0]          found_tag,
  output logic                erase_request,
  output logic [7:0]          program_slot,
  output logic [31:0]         record_crc,
  output logic                scan_done
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_REC_CRC, S_REC_CHECK, S_REC_SEARCH, S_REC_STORE,
    S_GET_SEARCH, S_SAVE_CRC, S_OUT_SEARCH, S_OUT_STORE
  } state_t;

  state_t state;
  logic [2:0] r_func;
  logic r_eok, r_pok;
  alrs_pkg::mode_t mode;
  logic [alrs_pkg::SLOT_W-1:0] free_slot, scan_pos, pend_slot;
  logic scan_running, pend_valid, pend_erase;
  logic save_erase;

  assign busy = state != S_IDLE;
  assign save_erase = (mode != alrs_pkg::MODE_READY) ||
                      (free_slot >= alrs_pkg::SLOT_W'(alrs_pkg::LOG_SLOTS));

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && start;
    case (state)
      S_DECODE: begin
        cmd.crc_init    = 1'b1;
        cmd.search_init = 1'b1;
        // save CRC runs over the captured fields with the fixed magic
        cmd.use_pend    = r_func == alrs_pkg::FN_SAVE;
      end
      S_REC_CRC:    cmd.crc_step = 1'b1;
      S_REC_SEARCH: cmd.search_step = 1'b1;
      S_REC_STORE:  cmd.cache_write = 1'b1;
      S_GET_SEARCH: cmd.search_step = 1'b1;
      S_SAVE_CRC: begin
        cmd.crc_step = 1'b1;
      end
      S_OUT_SEARCH: begin
        cmd.search_step = 1'b1;
        cmd.use_pend    = 1'b1;
      end
      S_OUT_STORE: begin
        cmd.cache_write = 1'b1;
        cmd.use_pend    = 1'b1;
      end
      default: ;
    endcase
    if (state == S_DECODE && r_func == alrs_pkg::FN_SCAN) cmd.cache_clear = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      mode         <= alrs_pkg::MODE_UNINIT;
      free_slot    <= '0;
      scan_pos     <= '0;
      scan_running <= 1'b0;
      pend_valid   <= 1'b0;
      pend_erase   <= 1'b0;
      pend_slot    <= '0;
      status       <= alrs_pkg::ST_IGNORED;
      found        <= 1'b0;
      found_value  <= '0;
      found_tag    <= '0;
      erase_request <= 1'b0;
      program_slot <= '0;
      record_crc   <= '0;
      scan_done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            r_func <= func;
            r_eok  <= erase_ok;
            r_pok  <= program_ok;
            state  <= S_DECODE;
          end
        end
        S_DECODE: begin
          status        <= alrs_pkg::ST_IGNORED;
          found         <= 1'b0;
          found_value   <= '0;
          found_tag     <= '0;
          erase_request <= 1'b0;
          program_slot  <= '0;
          record_crc    <= '0;
          scan_done     <= 1'b0;
          state         <= S_IDLE;
          case (r_func)
            alrs_pkg::FN_SCAN: begin
              mode         <= alrs_pkg::MODE_ERASE;
              scan_pos     <= '0;
              scan_running <= 1'b1;
              pend_valid   <= 1'b0;
              status       <= alrs_pkg::ST_OK;
              done         <= 1'b1;
            end
            alrs_pkg::FN_RECORD: begin
              if (scan_running) state <= S_REC_CRC;
              else done <= 1'b1;
            end
            alrs_pkg::FN_GET: state <= S_GET_SEARCH;
            alrs_pkg::FN_SAVE: begin
              if (mode == alrs_pkg::MODE_UNINIT) begin
                status <= alrs_pkg::ST_UNINIT;
                done   <= 1'b1;
              end else if (!scan_running && !pend_valid) begin
                state <= S_SAVE_CRC;
              end else begin
                done <= 1'b1;
              end
            end
            alrs_pkg::FN_OUTCOME: begin
              if (!pend_valid) begin
                done <= 1'b1;
              end else begin
                pend_valid <= 1'b0;
                if (pend_erase && !r_eok) begin
                  status <= alrs_pkg::ST_REJECTED;
                  done   <= 1'b1;
                end else begin
                  if (pend_erase) begin
                    mode      <= alrs_pkg::MODE_READY;
                    free_slot <= '0;
                  end
                  if (r_pok) begin
                    state <= S_OUT_SEARCH;
                  end else begin
                    status <= alrs_pkg::ST_REJECTED;
                    done   <= 1'b1;
                  end
                end
              end
            end
            default: done <= 1'b1;
          endcase
        end
        S_REC_CRC: if (stat.crc_done) state <= S_REC_CHECK;
        S_REC_CHECK: begin
          status <= alrs_pkg::ST_OK;
          if (stat.all_ff) begin
            mode         <= alrs_pkg::MODE_READY;
            free_slot    <= scan_pos;
            scan_running <= 1'b0;
            scan_done    <= 1'b1;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else if (!stat.magic_ok || !stat.crc_match) begin
            mode         <= alrs_pkg::MODE_ERASE;
            scan_running <= 1'b0;
            scan_done    <= 1'b1;
            status       <= alrs_pkg::ST_REJECTED;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            state <= S_REC_SEARCH;
          end
        end
        S_REC_SEARCH: if (stat.search_done) state <= S_REC_STORE;
        S_REC_STORE: begin
          if (!stat.hit && stat.cache_full) status <= alrs_pkg::ST_FULL;
          scan_pos <= scan_pos + 1'b1;
          if (scan_pos + 1'b1 >= alrs_pkg::SLOT_W'(alrs_pkg::LOG_SLOTS)) begin
            mode         <= alrs_pkg::MODE_ERASE;
            scan_running <= 1'b0;
            scan_done    <= 1'b1;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_GET_SEARCH: begin
          if (stat.search_done) begin
            status      <= alrs_pkg::ST_OK;
            found       <= get_hit;
            found_value <= get_value;
            found_tag   <= get_tag;
            done        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_SAVE_CRC: begin
          if (stat.crc_done) begin
            pend_erase    <= save_erase;
            pend_slot     <= save_erase ? '0 : free_slot;
            pend_kind     <= r_kind;
            pend_tag      <= r_tag;
            pend_value    <= r_value;
            pend_valid    <= 1'b1;
            erase_request <= save_erase;
            program_slot  <= save_erase ? 8'd0 : free_slot[7:0];
            record_crc    <= crc_in;
            status        <= alrs_pkg::ST_OK;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_OUT_SEARCH: if (stat.search_done) state <= S_OUT_STORE;
        S_OUT_STORE: begin
          status    <= (!stat.hit && stat.cache_full) ? alrs_pkg::ST_FULL : alrs_pkg::ST_OK;
          free_slot <= pend_slot + 1'b1;
          mode      <= alrs_pkg::MODE_READY;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/append_log_record_store.sv =====
// Append-only flash record log controller with a per-kind value cache.
// Top level; depends on alrs_pkg, alrs_ctrl and alrs_datapath.
//
// Usage: drive func and the record fields with start high while busy is low;
// the item is taken at that edge and busy rises the next cycle. Exactly one
// result comes back per item: done is high for one cycle with status, found*,
// erase_request, program_slot, record_crc and scan_done valid in that cycle.
// The receiver cannot stall; results must be taken when done is high.
// Sequence after accept: begin scan, ignored items and rejected outcomes end
// at decode; a get searches the cache entry by entry; a save runs the CRC, one
// CRC byte per cycle over eight header bytes; a scanned record runs the CRC,
// then stops the scan at the check or goes on to a cache search and store; a
// flash outcome that commits searches the cache, then stores.
// A new item may be accepted in the cycle in which done is high.
// Reset (rst, synchronous) leaves the log uninitialized, the cache empty and
// no save pending; a begin-scan item must precede saves.
module append_log_record_store (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [15:0] magic_word,
  input  logic [7:0]  kind,
  input  logic [7:0]  tag,
  input  logic [31:0] value,
  input  logic [31:0] crc_word,
  input  logic [31:0] pad_word,
  input  logic        erase_ok,
  input  logic        program_ok,
  output logic        done,
  output logic [2:0]  status,
  output logic        found,
  output logic [31:0] found_value,
  output logic [7:0]  found_tag,
  output logic        erase_request,
  output logic [7:0]  program_slot,
  output logic [31:0] record_crc,
  output logic        scan_done
);

  alrs_pkg::dp_cmd_t  cmd;
  alrs_pkg::dp_stat_t stat;
  logic [7:0]  r_kind, r_tag, pend_kind, pend_tag;
  logic [31:0] r_value, pend_value, crc_val, get_value;
  logic [7:0]  get_tag;
  logic        get_hit;

  alrs_ctrl u_ctrl (
    .clk, .rst, .start, .func, .erase_ok, .program_ok, .busy, .cmd, .stat,
    .r_kind, .r_tag, .r_value, .crc_in(crc_val), .get_hit, .get_value, .get_tag,
    .pend_kind, .pend_tag, .pend_value, .done, .status, .found, .found_value,
    .found_tag, .erase_request, .program_slot, .record_crc, .scan_done
  );

  alrs_datapath u_dp (
    .clk, .rst, .cmd, .stat, .magic_word, .kind, .tag, .value, .crc_word,
    .pad_word, .pend_kind, .pend_tag, .pend_value, .r_kind, .r_tag, .r_value,
    .crc_out(crc_val), .get_hit, .get_value, .get_tag
  );

endmodule

// ===== src/alrs_checker.sv =====
// Port-level checker for append_log_record_store, bound to the top level.
// Depends on the top level's port list and the status codes in alrs_pkg.
module alrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic        found,
  input logic        erase_request,
  input logic        scan_done
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("item taken without going busy");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while still busy");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result repeated");

  a_found_only_ok: assert property (@(posedge clk) disable iff (rst)
    done && found |-> status == alrs_pkg::ST_OK) else $error("found with bad status");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(found && (erase_request || scan_done)))
    else $error("result mixes unrelated fields");

endmodule

bind append_log_record_store alrs_checker u_alrs_checker (
  .clk, .rst, .start, .busy, .done, .status, .found, .erase_request, .scan_done
);
